>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, quiet while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/spm_pkg.sv
// Types, codes and the ranking key function of the spectral peak morph.
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;

   localparam int AMP_W = 16;
   localparam int KEY_W = 18;
   localparam logic [AMP_W-1:0] AMP_MAX = 16'hFFFF;

   localparam logic [2:0] CSR_KEY_MODE       = 3'd0;
   localparam logic [2:0] CSR_BLEND_MODE     = 3'd1;
   localparam logic [2:0] CSR_BLEND_AMOUNT   = 3'd2;
   localparam logic [2:0] CSR_SELECTED_COUNT = 3'd3;
   localparam logic [2:0] CSR_BINS_IN_USE    = 3'd4;

   localparam logic [2:0] KEY_ABS_DIFF  = 3'd0;
   localparam logic [2:0] KEY_MAIN_SIDE = 3'd1;
   localparam logic [2:0] KEY_SIDE_MAIN = 3'd2;
   localparam logic [2:0] KEY_SUM       = 3'd3;
   localparam logic [2:0] KEY_SIDE      = 3'd4;
   localparam logic [2:0] KEY_MAIN      = 3'd5;

   localparam logic [1:0] BLEND_REPLACE = 2'd0;
   localparam logic [1:0] BLEND_TOWARD  = 2'd1;
   localparam logic [1:0] BLEND_AWAY    = 2'd2;

   localparam logic [8:0] AMOUNT_ONE  = 9'd256;
   localparam logic [8:0] AMOUNT_HALF = 9'd128;

   typedef struct packed {
      logic [2:0]  key_mode;
      logic [1:0]  blend_mode;
      logic [8:0]  blend_amount;
      logic [10:0] selected_count;
   } cfg_type;

   // Ranking key, offset by half range so that unsigned order matches signed order.
   function automatic logic [KEY_W-1:0] bin_key(input logic [2:0] mode,
                                                input logic [AMP_W-1:0] m,
                                                input logic [AMP_W-1:0] s);
      logic signed [KEY_W-1:0] d;
      logic signed [KEY_W-1:0] k;
      d = $signed({2'b00, m}) - $signed({2'b00, s});
      unique case (mode)
         KEY_ABS_DIFF:  k = (d < 0) ? -d : d;
         KEY_MAIN_SIDE: k = d;
         KEY_SIDE_MAIN: k = -d;
         KEY_SUM:       k = $signed({2'b00, m}) + $signed({2'b00, s});
         KEY_SIDE:      k = $signed({2'b00, s});
         KEY_MAIN:      k = $signed({2'b00, m});
         default:       k = '0;
      endcase
      return k ^ {1'b1, {(KEY_W-1){1'b0}}};
   endfunction

endpackage
`default_nettype wire

>>> hdl/spm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> hdl/spm_front.sv
// Front end: accepts bins, tracks the frame position and queues work for the back end.
`timescale 1ns / 1ps
`default_nettype none
module spm_front #(
   parameter int MAX_BINS = 1024,
   localparam int IW = $clog2(MAX_BINS),
   localparam int NW = $clog2(MAX_BINS + 1),
   localparam int QW = IW + 1 + 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [NW-1:0] frame_len,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,
   output logic               q_valid,
   output logic [QW-1:0]      q_data,
   input  wire logic          q_pop
);
   logic [IW-1:0] pos_ff, pos_in;
   logic [1:0]    count_ff, count_in;
   logic [QW-1:0] slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic          push, last, wr_sel;

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign last       = NW'(pos_ff) >= (frame_len - NW'(1));
   assign q_valid    = (count_ff != 2'd0);
   assign q_data     = slot0_ff;
   assign wr_sel     = 1'((count_ff - {1'b0, q_pop}) != 2'd0);

   always_comb begin
      pos_in   = pos_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, q_pop};
      if (q_pop) begin
         slot0_in = slot1_ff;
      end
      if (push) begin
         pos_in = last ? '0 : pos_ff + IW'(1);
         if (wr_sel) begin
            slot1_in = {pos_ff, last, req_tdata};
         end else begin
            slot0_in = {pos_ff, last, req_tdata};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end
endmodule
`default_nettype wire

>>> hdl/spm_back.sv
// Back end: answers bins from the output store and ranks and morphs each finished frame.
`timescale 1ns / 1ps
`default_nettype none
module spm_back #(
   parameter int MAX_BINS = 1024,
   localparam int IW = $clog2(MAX_BINS),
   localparam int NW = $clog2(MAX_BINS + 1),
   localparam int QW = IW + 1 + 64,
   localparam int VW = spm_pkg::KEY_W + IW,
   localparam int BW = $clog2(VW),
   localparam int CW = (NW > 11) ? NW : 11
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire spm_pkg::cfg_type cfg,
   input  wire logic [NW-1:0]    frame_len,
   input  wire logic             q_valid,
   input  wire logic [QW-1:0]    q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_BITS  = 3'd3;
   localparam logic [2:0] ST_APPLY = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic [NW-1:0] rd_cnt_ff, rd_cnt_in;
   logic          rd_act_ff, rd_act_in;
   logic          p1_valid_ff;
   logic [IW-1:0] p1_idx_ff;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic [VW-1:0] thr_ff, thr_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic          sel_all_ff, sel_all_in, sel_none_ff, sel_none_in;
   logic          p2_valid_ff;
   logic [IW-1:0] p2_idx_ff;
   logic signed [26:0] p2_prod_ff;
   logic [15:0]   p2_base_ff, p2_ph_ff;

   logic          in_we, out_we, out_re;
   logic [IW-1:0] out_waddr;
   logic [31:0]   out_wdata, out_rdata;
   logic [63:0]   in_rdata;
   logic [IW-1:0] q_pos;
   logic          q_last;
   logic [63:0]   q_bin;

   logic [15:0]   m_amp, s_amp, m_ph, s_ph;
   logic [VW-1:0] v, cand;
   logic          hit, p1_end, p2_end, selected, take_side_ph;
   logic [CW-1:0] cnt_total, k_ext, n_ext;
   logic [8:0]    amt;
   logic signed [16:0] diff;
   logic [15:0]   base;
   logic signed [26:0] p1_prod, rnd, sum;
   logic [15:0]   amp_out;

   assign {q_pos, q_last, q_bin} = q_data;
   assign {s_ph, m_ph, s_amp, m_amp} = in_rdata;

   spm_ram #(.WIDTH(64), .DEPTH(MAX_BINS)) u_in_ram (
      .clock   (clock),
      .wr_en   (in_we),
      .wr_addr (q_pos),
      .wr_data (q_bin),
      .rd_en   (rd_act_ff),
      .rd_addr (rd_cnt_ff[IW-1:0]),
      .rd_data (in_rdata)
   );

   spm_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_out_ram (
      .clock   (clock),
      .wr_en   (out_we),
      .wr_addr (out_waddr),
      .wr_data (out_wdata),
      .rd_en   (out_re),
      .rd_addr (q_pos),
      .rd_data (out_rdata)
   );

   // Ordering value: key first, bin index breaks ties toward the higher index.
   assign v         = {spm_pkg::bin_key(cfg.key_mode, m_amp, s_amp), p1_idx_ff};
   assign cand      = thr_ff | (VW'(1) << bit_ff);
   assign hit       = p1_valid_ff && (v >= cand);
   assign cnt_total = CW'(cnt_ff) + CW'(hit);
   assign k_ext     = CW'(cfg.selected_count);
   assign n_ext     = CW'(frame_len);
   assign p1_end    = p1_valid_ff && (NW'(p1_idx_ff) == frame_len - NW'(1));
   assign p2_end    = p2_valid_ff && (NW'(p2_idx_ff) == frame_len - NW'(1));

   assign amt      = (cfg.blend_amount > spm_pkg::AMOUNT_ONE) ? spm_pkg::AMOUNT_ONE
                                                              : cfg.blend_amount;
   assign selected = !sel_none_ff && (sel_all_ff || (v >= thr_ff));

   always_comb begin
      diff         = '0;
      base         = m_amp;
      take_side_ph = 1'b0;
      if (selected) begin
         unique case (cfg.blend_mode)
            spm_pkg::BLEND_REPLACE: begin
               base         = '0;
               diff         = $signed({1'b0, s_amp});
               take_side_ph = 1'b1;
            end
            spm_pkg::BLEND_TOWARD: begin
               diff         = $signed({1'b0, s_amp}) - $signed({1'b0, m_amp});
               take_side_ph = amt > spm_pkg::AMOUNT_HALF;
            end
            spm_pkg::BLEND_AWAY: begin
               diff         = $signed({1'b0, m_amp}) - $signed({1'b0, s_amp});
               take_side_ph = amt < spm_pkg::AMOUNT_HALF;
            end
            default: begin
               diff = '0;
            end
         endcase
      end
   end

   assign p1_prod = $signed({1'b0, amt}) * diff;
   assign rnd     = (p2_prod_ff + 27'sd128) >>> 8;
   assign sum     = $signed({11'd0, p2_base_ff}) + rnd;
   assign amp_out = (sum < 0) ? '0
                  : (sum > $signed({11'd0, spm_pkg::AMP_MAX})) ? spm_pkg::AMP_MAX
                  : sum[15:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_act_in    = rd_act_ff;
      cnt_in       = cnt_ff;
      thr_in       = thr_ff;
      bit_in       = bit_ff;
      sel_all_in   = sel_all_ff;
      sel_none_in  = sel_none_ff;
      q_pop        = 1'b0;
      in_we        = 1'b0;
      out_re       = 1'b0;
      out_we       = p2_valid_ff;
      out_waddr    = p2_idx_ff;
      out_wdata    = {p2_ph_ff, amp_out};

      if (rd_act_ff) begin
         rd_cnt_in = rd_cnt_ff + NW'(1);
         if (rd_cnt_ff == frame_len - NW'(1)) begin
            rd_act_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            out_we    = 1'b1;
            out_waddr = clr_ff;
            out_wdata = '0;
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == IW'(MAX_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && (!rsp_valid_ff || rsp_tready)) begin
               q_pop    = 1'b1;
               in_we    = 1'b1;
               out_re   = 1'b1;
               last_in  = q_last;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = out_rdata;
            rsp_last_in  = last_ff;
            if (last_ff) begin
               rd_cnt_in   = '0;
               rd_act_in   = 1'b1;
               cnt_in      = '0;
               thr_in      = '0;
               bit_in      = BW'(VW - 1);
               sel_none_in = (k_ext == '0);
               sel_all_in  = (k_ext >= n_ext);
               state_in    = ((k_ext == '0) || (k_ext >= n_ext)) ? ST_APPLY : ST_BITS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_BITS: begin
            // One bit of the threshold per pass over the frame.
            cnt_in = NW'(cnt_total);
            if (p1_end) begin
               if (cnt_total >= k_ext) begin
                  thr_in = cand;
               end
               cnt_in    = '0;
               rd_cnt_in = '0;
               rd_act_in = 1'b1;
               if (bit_ff == '0) begin
                  state_in = ST_APPLY;
               end else begin
                  bit_in = bit_ff - BW'(1);
               end
            end
         end
         ST_APPLY: begin
            if (p2_end) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_act_ff    <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_act_ff    <= rd_act_in;
         p1_valid_ff  <= rd_act_ff;
         p2_valid_ff  <= p1_valid_ff && (state_ff == ST_APPLY);
      end
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rd_cnt_ff   <= rd_cnt_in;
      p1_idx_ff   <= rd_cnt_ff[IW-1:0];
      cnt_ff      <= cnt_in;
      thr_ff      <= thr_in;
      bit_ff      <= bit_in;
      sel_all_ff  <= sel_all_in;
      sel_none_ff <= sel_none_in;
      p2_idx_ff   <= p1_idx_ff;
      p2_prod_ff  <= p1_prod;
      p2_base_ff  <= base;
      p2_ph_ff    <= take_side_ph ? s_ph : m_ph;
   end
endmodule
`default_nettype wire

>>> hdl/spectral_peak_morph.sv
// Top level of the spectral peak morph: configuration registers, front end and back end.
`timescale 1ns / 1ps
`default_nettype none
// The block takes one spectral bin per req transaction and answers each with one
// rsp transaction that carries the processed bin at the same position of the
// previous frame; the first frame after reset answers with zeros. rsp_tlast marks
// the last bin of a frame. A front end counts the frame position and queues up
// to two bins; a back end owns the input and output bin memories.
// An ordinary bin passes through the queue, the output memory read and the rsp register.
// The transaction that ends a frame starts the ranking of the stored frame: the
// K-th strongest ordering value (key, then bin index) is found by bisection, one
// bit per pass over the input memory, which takes (18 + log2(MAX_BINS)) passes,
// followed by one more pass that morphs the selected bins into the output memory.
// Each pass reads the frame through the single read port of the input memory;
// the front end queues at most two new bins meanwhile. When selected_count is
// zero or covers the whole frame the bisection is skipped. After reset the output
// memory is cleared, one entry a cycle; bins are still queued meanwhile. A stalled
// rsp holds its transaction while the queue keeps taking bins until it is full.
// Configuration is written through csr_we, csr_addr and csr_wdata; the user must
// write it only while the block is idle, and the block itself does not enforce this.
module spectral_peak_morph #(
   parameter int MAX_BINS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // main_amplitude [15:0], side_amplitude [31:16], main_phase [47:32], side_phase [63:48]
   input  wire logic [63:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_amplitude [15:0], out_phase [31:16]
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [10:0] csr_wdata
);
   localparam int IW = $clog2(MAX_BINS);
   localparam int NW = $clog2(MAX_BINS + 1);
   localparam int QW = IW + 1 + 64;
   localparam int CW = (NW > 11) ? NW : 11;

   spm_pkg::cfg_type cfg_ff, cfg_in;
   logic [10:0]      bins_ff, bins_in;
   logic [NW-1:0]    frame_len;
   logic             q_valid, q_pop;
   logic [QW-1:0]    q_data;

   always_comb begin
      cfg_in  = cfg_ff;
      bins_in = bins_ff;
      if (csr_we) begin
         unique case (csr_addr)
            spm_pkg::CSR_KEY_MODE:       cfg_in.key_mode       = csr_wdata[2:0];
            spm_pkg::CSR_BLEND_MODE:     cfg_in.blend_mode     = csr_wdata[1:0];
            spm_pkg::CSR_BLEND_AMOUNT:   cfg_in.blend_amount   = csr_wdata[8:0];
            spm_pkg::CSR_SELECTED_COUNT: cfg_in.selected_count = csr_wdata;
            spm_pkg::CSR_BINS_IN_USE:    bins_in               = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '0;
         bins_ff <= 11'd1024;
      end else begin
         cfg_ff  <= cfg_in;
         bins_ff <= bins_in;
      end
   end

   // Frame length clamped to the range two to MAX_BINS.
   assign frame_len = (bins_ff < 11'd2) ? NW'(2)
                    : (CW'(bins_ff) > CW'(MAX_BINS)) ? NW'(MAX_BINS)
                    : NW'(bins_ff);

   spm_front #(.MAX_BINS(MAX_BINS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .frame_len  (frame_len),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop)
   );

   spm_back #(.MAX_BINS(MAX_BINS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .frame_len  (frame_len),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule
`default_nettype wire

>>> hdl/spm_checker.sv
// Port-level checks of the spectral peak morph and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   // No answer is pending right after reset.
   `ASSERT_NEXT_ALWAYS(a_rsp_idle_after_reset, clock, reset, !rsp_tvalid)
   // A stalled answer keeps its transaction.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   // The back end needs a memory read between two answers.
   `ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid)
endmodule

bind spectral_peak_morph spm_checker u_spm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the spectral peak morph block.
`timescale 1ns / 1ps
`default_nettype none
// Bins are streamed in as req transactions and every rsp transaction is
// checked field by field against its typed-in result or against a predictor
// that keeps its own copy of the bin memories and the configuration. Every frame
// writes each of its bins before it is ranked, so no unwritten bin is ever read.
// Configuration is changed only between phases, once every expected transaction
// has arrived and the ranking that a frame end starts has had time to finish.
module testbench;

   localparam int NBINS = 1024;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 600;

   typedef struct {
      logic [15:0] amp;
      logic [15:0] ph;
      logic        last;
   } morph_result_t;

   typedef struct {
      logic [15:0] m_amp;
      logic [15:0] s_amp;
      logic [15:0] m_ph;
      logic [15:0] s_ph;
   } bin_t;

   // One row of the directed table; known rows carry a typed-in result.
   typedef struct {
      bin_t          bin;
      bit            known;
      morph_result_t res;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [10:0] csr_wdata = '0;

   spectral_peak_morph DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: configuration, frame position and the bin memories.
   logic [2:0]  key_sel;
   logic [1:0]  blend_sel;
   logic [8:0]  amount;
   logic [10:0] sel_count;
   logic [10:0] frame_size;
   int unsigned position;
   bin_t        stored_bins [NBINS];
   logic [15:0] morphed_amp [NBINS];
   logic [15:0] morphed_ph [NBINS];

   morph_result_t pending_results [$];
   int  mismatches = 0;
   int  idle_cycles = 0;
   int  frames_done = 0;
   int  random_sent = 0;
   bit  quiet = 1'b0;
   bit  last_ended_frame = 1'b0;
   int  last_frame_size = 0;

   function automatic int unsigned clamped_size();
      if (frame_size < 2) return 2;
      if (frame_size > NBINS) return NBINS;
      return int'(frame_size);
   endfunction

   function automatic longint rank_key(bin_t b);
      longint d;
      d = longint'(b.m_amp) - longint'(b.s_amp);
      case (key_sel)
         spm_pkg::KEY_ABS_DIFF:  return (d < 0) ? -d : d;
         spm_pkg::KEY_MAIN_SIDE: return d;
         spm_pkg::KEY_SIDE_MAIN: return -d;
         spm_pkg::KEY_SUM:       return longint'(b.m_amp) + longint'(b.s_amp);
         spm_pkg::KEY_SIDE:      return longint'(b.s_amp);
         spm_pkg::KEY_MAIN:      return longint'(b.m_amp);
         default:                return 0;
      endcase
   endfunction

   function automatic longint sat16(longint v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   // Ranks the stored frame and morphs the strongest bins into the output memory.
   function automatic void morph_frame(int unsigned n);
      longint keys [NBINS];
      longint a, amp, m, s;
      logic [15:0] ph;
      int unsigned stronger;
      a = (amount > spm_pkg::AMOUNT_ONE) ? 256 : longint'(amount);
      for (int i = 0; i < n; i++) keys[i] = rank_key(stored_bins[i]);
      for (int i = 0; i < n; i++) begin
         stronger = 0;
         for (int j = 0; j < n; j++)
            if (keys[j] > keys[i] || (keys[j] == keys[i] && j > i)) stronger++;
         m = longint'(stored_bins[i].m_amp);
         s = longint'(stored_bins[i].s_amp);
         amp = m;
         ph = stored_bins[i].m_ph;
         if (stronger < sel_count) begin
            case (blend_sel)
               spm_pkg::BLEND_REPLACE: begin
                  amp = sat16((a * s + 128) >>> 8);
                  ph = stored_bins[i].s_ph;
               end
               spm_pkg::BLEND_TOWARD: begin
                  amp = sat16(m + ((a * (s - m) + 128) >>> 8));
                  if (a > spm_pkg::AMOUNT_HALF) ph = stored_bins[i].s_ph;
               end
               spm_pkg::BLEND_AWAY: begin
                  amp = sat16(m + ((a * (m - s) + 128) >>> 8));
                  if (a < spm_pkg::AMOUNT_HALF) ph = stored_bins[i].s_ph;
               end
               default: ;
            endcase
         end
         morphed_amp[i] = amp[15:0];
         morphed_ph[i] = ph;
      end
   endfunction

   // Result of one accepted bin; also advances the predictor state.
   function automatic morph_result_t accept_bin(bin_t b);
      morph_result_t r;
      int unsigned n, p;
      n = clamped_size();
      p = (position >= NBINS) ? NBINS - 1 : position;
      r.amp = morphed_amp[p];
      r.ph = morphed_ph[p];
      r.last = (p >= n - 1);
      stored_bins[p] = b;
      if (r.last) begin
         morph_frame(n);
         position = 0;
         frames_done++;
         last_frame_size = n;
      end else begin
         position = p + 1;
      end
      last_ended_frame = r.last;
      return r;
   endfunction

   function automatic bin_t random_bin();
      bin_t b;
      b.m_amp = 16'($urandom());
      b.s_amp = 16'($urandom());
      b.m_ph = 16'($urandom());
      b.s_ph = 16'($urandom());
      case ($urandom_range(0, 7))
         0: b.m_amp = 16'hFFFF;
         1: b.s_amp = 16'h0000;
         2: b.s_amp = b.m_amp;               // equal amplitudes tie on most keys
         3: b.m_amp = 16'($urandom_range(0, 15));
         default: ;
      endcase
      return b;
   endfunction

   // Sends one bin, with a random gap in front of it unless the run is quiet.
   task automatic send_bin(bin_t b, bit known, morph_result_t typed);
      morph_result_t r;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tdata <= {b.s_ph, b.m_ph, b.s_amp, b.m_amp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = accept_bin(b);
      pending_results.push_back(known ? typed : r);
   endtask

   // Waits for every expected transaction, then for any ranking still running.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (last_ended_frame ? 32 * last_frame_size + 64 : 16) @(posedge clock);
   endtask

   // Writes all five registers, one per cycle, and mirrors them in the predictor.
   task automatic write_config(logic [2:0] k, logic [1:0] bm, logic [8:0] am,
                               logic [10:0] sc, logic [10:0] nb);
      logic [2:0]  idx [5];
      logic [10:0] val [5];
      idx = '{spm_pkg::CSR_KEY_MODE, spm_pkg::CSR_BLEND_MODE, spm_pkg::CSR_BLEND_AMOUNT,
              spm_pkg::CSR_SELECTED_COUNT, spm_pkg::CSR_BINS_IN_USE};
      val = '{11'(k), 11'(bm), 11'(am), sc, nb};
      for (int i = 0; i < 5; i++) begin
         csr_we <= 1'b1;
         csr_addr <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      key_sel = k;
      blend_sel = bm;
      amount = am;
      sel_count = sc;
      frame_size = nb;
   endtask

   // Result side: random stall bursts, checking and the watchdog.
   int stall_left = 0;
   always @(posedge clock) begin
      morph_result_t want;
      logic next_ready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("** spectral_peak_morph: FAILED **");
            $finish;
         end
      end
      if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp transaction: amp %h phase %h last %b",
                        rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[15:0] !== want.amp || rsp_tdata[31:16] !== want.ph ||
                rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected amp %h phase %h last %b, got %h %h %b",
                           want.amp, want.ph, want.last,
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
            end
         end
      end
      next_ready = 1'b1;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         next_ready = 1'b0;
      end else if (!reset && !quiet && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 3);
         next_ready = 1'b0;
      end
      rsp_tready <= next_ready;
   end

   initial begin
      stim_row_t directed [12];
      morph_result_t zero_res;
      morph_result_t none;
      bin_t b;
      int unsigned n, items;
      logic [10:0] nb, sc;
      logic [8:0] am;

      zero_res = '{amp: 16'h0000, ph: 16'h0000, last: 1'b0};
      none = zero_res;
      // Extremes of every field; the first frame after reset reads back zeros.
      directed = '{
         '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1, zero_res},
         '{'{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000}, 1'b1, zero_res},
         '{'{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF}, 1'b1, zero_res},
         '{'{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000}, 1'b1, zero_res},
         '{'{16'h8000, 16'h8000, 16'h0001, 16'hFFFF}, 1'b1, zero_res},
         '{'{16'h0001, 16'h0002, 16'h5555, 16'hAAAA}, 1'b1, zero_res},
         '{'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 1'b1, zero_res},
         '{'{16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB}, 1'b1, zero_res},
         '{'{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF}, 1'b1, zero_res},
         '{'{16'h0080, 16'h0080, 16'h7FFF, 16'h7FFF}, 1'b1, zero_res},
         '{'{16'hFFFE, 16'h0001, 16'h8000, 16'h8000}, 1'b1, zero_res},
         '{'{16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0}, 1'b1, zero_res}};

      key_sel = spm_pkg::KEY_ABS_DIFF;
      blend_sel = spm_pkg::BLEND_REPLACE;
      amount = '0;
      sel_count = '0;
      frame_size = 11'd1024;
      position = 0;
      for (int i = 0; i < NBINS; i++) begin
         stored_bins[i] = '{16'h0, 16'h0, 16'h0, 16'h0};
         morphed_amp[i] = '0;
         morphed_ph[i] = '0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Start of the first frame with reset settings; every answer is still zero.
      foreach (directed[i]) send_bin(directed[i].bin, directed[i].known, directed[i].res);
      drain();

      // A size above MAX_BINS continues the same frame; the next phase shrinks it.
      write_config(spm_pkg::KEY_MAIN, spm_pkg::BLEND_TOWARD, 9'd200, 11'd7, 11'd2047);
      for (int i = 0; i < 20; i++) send_bin(random_bin(), 1'b0, none);
      drain();

      // Forced settings first: amount above one, unknown key and blend modes,
      // sizes below two, count above the frame; then random settings.
      for (int ph = 0; random_sent < RANDOM_ITEMS; ph++) begin
         case (ph)
            0: write_config(spm_pkg::KEY_ABS_DIFF, spm_pkg::BLEND_REPLACE, 9'd511, 11'd3,
                            11'd8);
            1: write_config(3'd6, spm_pkg::BLEND_AWAY, 9'd0, 11'd2, 11'd5);
            2: write_config(3'd7, 2'd3, 9'd256, 11'd2047, 11'd1);
            3: write_config(spm_pkg::KEY_SUM, spm_pkg::BLEND_AWAY, 9'd127, 11'd0, 11'd0);
            4: write_config(spm_pkg::KEY_SIDE_MAIN, spm_pkg::BLEND_TOWARD, 9'd128, 11'd9,
                            11'd9);
            5: write_config(spm_pkg::KEY_SIDE, spm_pkg::BLEND_TOWARD, 9'd129, 11'd1, 11'd16);
            6: write_config(spm_pkg::KEY_MAIN_SIDE, spm_pkg::BLEND_AWAY, 9'd128, 11'd4,
                            11'd3);
            default: begin
               case ($urandom_range(0, 9))
                  0: nb = 11'($urandom_range(0, 1));
                  1: nb = 11'($urandom_range(17, 64));
                  default: nb = 11'($urandom_range(2, 16));
               endcase
               case ($urandom_range(0, 4))
                  0: sc = 11'd0;
                  1: sc = 11'($urandom_range(0, 2047));
                  default: sc = 11'($urandom_range(1, (nb < 2) ? 2 : nb));
               endcase
               case ($urandom_range(0, 5))
                  0: am = spm_pkg::AMOUNT_ONE;
                  1: am = spm_pkg::AMOUNT_HALF;
                  2: am = 9'($urandom_range(257, 511));
                  default: am = 9'($urandom_range(0, 256));
               endcase
               write_config(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), am, sc, nb);
            end
         endcase
         n = clamped_size();
         items = $urandom_range(1, (3 * n > 96) ? 96 : 3 * n);
         for (int i = 0; i < items; i++) begin
            quiet = (random_sent >= RANDOM_ITEMS - 80);
            send_bin(random_bin(), 1'b0, none);
            random_sent++;
         end
         drain();
      end

      repeat (64) @(posedge clock);
      $display("Covered %0d frames: every key and blend mode, frame sizes clamped at",
               frames_done);
      $display("both ends, amounts and counts at their limits and %0d random bins.",
               random_sent);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("** spectral_peak_morph: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  pending_results.size());
         $display("** spectral_peak_morph: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> spectral_peak_morph.f
+incdir+hdl
hdl/spm_pkg.sv
hdl/spm_ram.sv
hdl/spm_front.sv
hdl/spm_back.sv
hdl/spectral_peak_morph.sv
hdl/spm_checker.sv
tb/testbench.sv
